// File: rtl/core/gbi_pkg.sv
// ----------------------------------------------------------------------------
// gbi_pkg: shared types and constants for the grid interpolator
// Transfer payload structs, command codes and register indexes.
// ----------------------------------------------------------------------------
package gbi_pkg;

  localparam int MaxCols   = 64;
  localparam int MaxRows   = 64;
  localparam int ValueBits = 16;
  localparam int Depth     = MaxCols * MaxRows;
  localparam int AddrBits  = $clog2(Depth);

  // divider pipeline depth: one quotient bit per stage
  localparam int QuotBits  = 24;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 32;

  localparam logic [1:0] CmdWrite  = 2'd0;
  localparam logic [1:0] CmdRead   = 2'd1;
  localparam logic [1:0] CmdInterp = 2'd2;

  localparam logic [CfgIdxBits-1:0] CfgOriginX = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgOriginY = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgStepX   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgStepY   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgCols    = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgRows    = 3'd5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         col;
    logic [5:0]         row;
    logic [15:0]        cell_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [23:0] interp_value;
    logic        status;
  } out_item_t;

endpackage

// File: rtl/core/grid_bilinear_interpolator.sv
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator: cell store with bilinear lookup
// Grid cells live in one single-port memory; queries map a point to a cell
// and remainder, read four corners and divide the weighted sum.
// ----------------------------------------------------------------------------
// Memory port: every item makes four corner accesses on the single grid
//   memory port (writes and reads too), so items take that port in turn.
// Path: from input transfer to result valid, an item passes the index stage,
//   the memory slots, the product registers and the 25 divider stages.
// Reset: config returns to defaults; a clearing pass then zeroes all 4096
//   cells, one per cycle, with the input stalled until the pass ends.
module grid_bilinear_interpolator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  gbi_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output gbi_pkg::out_item_t               out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gbi_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [gbi_pkg::CfgDataBits-1:0]  cfg_data_i
);

  localparam int NS = gbi_pkg::QuotBits;
  localparam int AW = gbi_pkg::AddrBits;
  localparam int VB = gbi_pkg::ValueBits;

  // ---------------- config ----------------
  logic [31:0] origin_x_q, origin_y_q;
  logic [15:0] step_x_q, step_y_q;
  logic [6:0]  grid_cols_q, grid_rows_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      step_x_q    <= 16'd1;
      step_y_q    <= 16'd1;
      grid_cols_q <= 7'(gbi_pkg::MaxCols);
      grid_rows_q <= 7'(gbi_pkg::MaxRows);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gbi_pkg::CfgOriginX: origin_x_q  <= cfg_data_i;
        gbi_pkg::CfgOriginY: origin_y_q  <= cfg_data_i;
        gbi_pkg::CfgStepX:   step_x_q    <= cfg_data_i[15:0];
        gbi_pkg::CfgStepY:   step_y_q    <= cfg_data_i[15:0];
        gbi_pkg::CfgCols:    grid_cols_q <= cfg_data_i[6:0];
        gbi_pkg::CfgRows:    grid_rows_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic [15:0] sx, sy;
  logic [6:0]  cols, rows;

  assign sx   = (step_x_q == '0) ? 16'd1 : step_x_q;
  assign sy   = (step_y_q == '0) ? 16'd1 : step_y_q;
  assign cols = (grid_cols_q == '0) ? 7'd1 :
                (grid_cols_q > 7'(gbi_pkg::MaxCols)) ? 7'(gbi_pkg::MaxCols) : grid_cols_q;
  assign rows = (grid_rows_q == '0) ? 7'd1 :
                (grid_rows_q > 7'(gbi_pkg::MaxRows)) ? 7'(gbi_pkg::MaxRows) : grid_rows_q;

  // one restoring step of the index division; returns {quotient bit, rem}
  function automatic logic [22:0] div_step(logic [21:0] rem, logic [15:0] s,
                                           logic [2:0] k);
    logic [21:0] dv;
    dv = 22'(s) << k;
    if (rem >= dv) return {1'b1, 22'(rem - dv)};
    else return {1'b0, rem};
  endfunction

  // one quotient bit of the result divider; returns {bit, rem}
  function automatic logic [32:0] qdiv_step(logic [31:0] rem, logic nbit,
                                            logic [31:0] d);
    logic [32:0] t;
    t = {rem, nbit};
    if (t >= {1'b0, d}) return {1'b1, 32'(t - {1'b0, d})};
    else return {1'b0, t[31:0]};
  endfunction

  // ---------------- clearing pass ----------------
  logic          clr_active_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(gbi_pkg::Depth - 1)) clr_active_q <= 1'b0;
    end
  end

  // ---------------- pipeline enable ----------------
  logic dv_valid_q [NS+1];
  logic adv;

  assign adv = !dv_valid_q[NS] || !out_stall_i;

  // ---------------- index stage ----------------
  logic        a_valid_q;
  logic [1:0]  a_cnt_q;
  logic [1:0]  a_cmd_q;
  logic [5:0]  a_col_q, a_row_q;
  logic [15:0] a_val_q;
  logic        a_ovx_q, a_ovy_q;
  logic [21:0] a_remx_q, a_remy_q;
  logic [5:0]  a_qx_q, a_qy_q;

  logic a_accept, a_leave, b_free, b_load, b_busy_q, b_issue;
  logic [1:0] b_k_q;

  assign b_issue  = b_busy_q && adv;
  assign b_free   = !b_busy_q || (b_k_q == 2'd3 && adv);
  assign a_leave  = a_valid_q && (a_cnt_q == 2'd3) && b_free;
  assign b_load   = a_leave;
  assign in_stall_o = clr_active_q || (a_valid_q && !a_leave);
  assign a_accept = in_valid_i && !in_stall_o;

  logic [32:0] dx, dy;
  logic        ovx, ovy;

  assign dx  = {in_item_i.point_x[31], in_item_i.point_x} - {origin_x_q[31], origin_x_q};
  assign dy  = {in_item_i.point_y[31], in_item_i.point_y} - {origin_y_q[31], origin_y_q};
  // negative or at least 64 steps away: no grid column can match
  assign ovx = dx[32] || (dx[31:22] != '0) || (dx[21:0] >= {sx, 6'd0});
  assign ovy = dy[32] || (dy[31:22] != '0) || (dy[21:0] >= {sy, 6'd0});

  logic [2:0]  k_hi, k_lo;
  logic [22:0] sx_hi, sx_lo, sy_hi, sy_lo;

  assign k_hi  = 3'd5 - {a_cnt_q, 1'b0};
  assign k_lo  = k_hi - 3'd1;
  assign sx_hi = div_step(a_remx_q, sx, k_hi);
  assign sx_lo = div_step(sx_hi[21:0], sx, k_lo);
  assign sy_hi = div_step(a_remy_q, sy, k_hi);
  assign sy_lo = div_step(sy_hi[21:0], sy, k_lo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_cnt_q   <= '0;
    end else if (a_accept) begin
      a_valid_q <= 1'b1;
      a_cnt_q   <= '0;
    end else begin
      if (a_leave) a_valid_q <= 1'b0;
      if (a_valid_q && a_cnt_q != 2'd3) a_cnt_q <= a_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_accept) begin
      a_cmd_q  <= in_item_i.cmd;
      a_col_q  <= in_item_i.col;
      a_row_q  <= in_item_i.row;
      a_val_q  <= in_item_i.cell_value;
      a_ovx_q  <= ovx;
      a_ovy_q  <= ovy;
      a_remx_q <= dx[21:0];
      a_remy_q <= dy[21:0];
      a_qx_q   <= '0;
      a_qy_q   <= '0;
    end else if (a_valid_q && a_cnt_q != 2'd3) begin
      a_remx_q <= sx_lo[21:0];
      a_remy_q <= sy_lo[21:0];
      a_qx_q   <= a_qx_q | (6'(sx_hi[22]) << k_hi) | (6'(sx_lo[22]) << k_lo);
      a_qy_q   <= a_qy_q | (6'(sy_hi[22]) << k_hi) | (6'(sy_lo[22]) << k_lo);
    end
  end

  // ---------------- handoff: error, weights, base address ----------------
  logic [5:0]  ci, rj;
  logic [15:0] rx, ry;
  logic        err, zero_w;

  always_comb begin
    ci  = a_col_q;
    rj  = a_row_q;
    rx  = '0;
    ry  = '0;
    err = 1'b0;
    case (a_cmd_q)
      gbi_pkg::CmdWrite, gbi_pkg::CmdRead: begin
        err = ({1'b0, a_col_q} >= cols) || ({1'b0, a_row_q} >= rows);
      end
      gbi_pkg::CmdInterp: begin
        ci  = a_qx_q;
        rj  = a_qy_q;
        rx  = a_remx_q[15:0];
        ry  = a_remy_q[15:0];
        err = a_ovx_q || a_ovy_q || ({1'b0, a_qx_q} >= cols) || ({1'b0, a_qy_q} >= rows) ||
              ((rx != '0) && ({1'b0, a_qx_q} + 7'd1 >= cols)) ||
              ((ry != '0) && ({1'b0, a_qy_q} + 7'd1 >= rows));
      end
      default: err = 1'b1;
    endcase
  end

  assign zero_w = err || (a_cmd_q == gbi_pkg::CmdWrite);

  logic [15:0] wx0, wy0;
  logic [12:0] base_full;

  assign wx0       = sx - rx;
  assign wy0       = sy - ry;
  assign base_full = 13'(ci) + 13'(cols) * 13'(rj);

  // ---------------- memory slot sequencer ----------------
  logic [31:0]   b_w_q [4];
  logic [31:0]   b_d_q;
  logic          b_st_q, b_we_q;
  logic [VB-1:0] b_wdata_q;
  logic [AW-1:0] b_base_q, b_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_busy_q <= 1'b0;
      b_k_q    <= '0;
    end else if (b_load) begin
      b_busy_q <= 1'b1;
      b_k_q    <= '0;
    end else if (b_issue) begin
      if (b_k_q == 2'd3) b_busy_q <= 1'b0;
      b_k_q <= b_k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_w_q[0]  <= zero_w ? '0 : wx0 * wy0;
      b_w_q[1]  <= zero_w ? '0 : rx * wy0;
      b_w_q[2]  <= zero_w ? '0 : wx0 * ry;
      b_w_q[3]  <= zero_w ? '0 : rx * ry;
      b_d_q     <= sx * sy;
      b_st_q    <= err;
      b_we_q    <= (a_cmd_q == gbi_pkg::CmdWrite) && !err;
      b_wdata_q <= a_val_q[VB-1:0];
      b_base_q  <= base_full[AW-1:0];
    end
  end

  // corners: (i,j) (i+1,j) (i,j+1) (i+1,j+1)
  always_comb begin
    case (b_k_q)
      2'd0:    b_addr = b_base_q;
      2'd1:    b_addr = b_base_q + AW'(1);
      2'd2:    b_addr = b_base_q + AW'(cols);
      default: b_addr = b_base_q + AW'(cols) + AW'(1);
    endcase
  end

  logic [VB-1:0] grid_mem [gbi_pkg::Depth];
  logic [VB-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      grid_mem[clr_cnt_q] <= '0;
    end else if (b_issue) begin
      if (b_k_q == 2'd0 && b_we_q) grid_mem[b_addr] <= b_wdata_q;
      else rd_q <= grid_mem[b_addr];
    end
  end

  // ---------------- weight and sum ----------------
  logic        p1_valid_q, p1_first_q, p1_last_q, p1_st_q;
  logic [31:0] p1_w_q, p1_d_q;
  logic        p2_valid_q, p2_first_q, p2_last_q, p2_st_q;
  logic [47:0] p2_prod_q, acc_q, sum_c;
  logic [31:0] p2_d_q;

  assign sum_c = (p2_first_q ? 48'd0 : acc_q) + p2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else if (adv) begin
      p1_valid_q <= b_busy_q;
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_first_q <= (b_k_q == 2'd0);
      p1_last_q  <= (b_k_q == 2'd3);
      p1_w_q     <= b_w_q[b_k_q];
      p1_d_q     <= b_d_q;
      p1_st_q    <= b_st_q;
      p2_first_q <= p1_first_q;
      p2_last_q  <= p1_last_q;
      p2_prod_q  <= rd_q * p1_w_q;
      p2_d_q     <= p1_d_q;
      p2_st_q    <= p1_st_q;
      if (p2_valid_q) acc_q <= sum_c;
    end
  end

  // ---------------- result divider: floor(256*S/D) ----------------
  // sum <= 65535*D, so the quotient always fits 24 bits and the high
  // dividend part starts below D
  logic [31:0] dv_rem_q [NS+1];
  logic [23:0] dv_low_q [NS+1];
  logic [23:0] dv_quo_q [NS+1];
  logic [31:0] dv_d_q   [NS+1];
  logic        dv_st_q  [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) dv_valid_q[s] <= 1'b0;
    end else if (adv) begin
      dv_valid_q[0] <= p2_valid_q && p2_last_q;
      for (int s = 1; s <= NS; s++) dv_valid_q[s] <= dv_valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [32:0] st;
    if (adv) begin
      dv_rem_q[0] <= sum_c[47:16];
      dv_low_q[0] <= {sum_c[15:0], 8'd0};
      dv_quo_q[0] <= '0;
      dv_d_q[0]   <= p2_d_q;
      dv_st_q[0]  <= p2_st_q;
      for (int s = 1; s <= NS; s++) begin
        st = qdiv_step(dv_rem_q[s-1], dv_low_q[s-1][23], dv_d_q[s-1]);
        dv_rem_q[s] <= st[31:0];
        dv_low_q[s] <= {dv_low_q[s-1][22:0], 1'b0};
        dv_quo_q[s] <= {dv_quo_q[s-1][22:0], st[32]};
        dv_d_q[s]   <= dv_d_q[s-1];
        dv_st_q[s]  <= dv_st_q[s-1];
      end
    end
  end

  assign out_valid_o             = dv_valid_q[NS];
  assign out_item_o.interp_value = dv_quo_q[NS];
  assign out_item_o.status       = dv_st_q[NS];

  // ---------------- checks ----------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> in_stall_o)
    else $error("input taken during clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !b_busy_q)
    else $error("memory port shared by clear and slot access");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status) |-> (out_item_o.interp_value == '0))
    else $error("error result carries a value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid_q[NS] |-> (dv_rem_q[NS] < dv_d_q[NS]))
    else $error("divider remainder not below divisor");

endmodule

// File: sim/gbi_checker.sv
// ----------------------------------------------------------------------------
// gbi_checker: result predictor and scoreboard for the grid interpolator
// Watches the input, output and config channels, models the grid store and
// the lookup math, and compares every output transfer with the oldest
// expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbi_checker
  import gbi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  in_item_t               in_item_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  out_item_t              out_item_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output int                     pending_o,
  output int                     errors_o
);

  localparam longint unsigned OutMax = 64'hFF_FFFF;

  logic [15:0] cells [Depth];
  logic [31:0] org_x, org_y;
  logic [15:0] stp_x, stp_y;
  logic [6:0]  n_cols, n_rows;
  out_item_t   expected_q[$];

  assign pending_o = expected_q.size();

  function automatic longint unsigned eff_cols();
    if (n_cols == 0) return 1;
    return (n_cols > MaxCols) ? MaxCols : n_cols;
  endfunction

  function automatic longint unsigned eff_rows();
    if (n_rows == 0) return 1;
    return (n_rows > MaxRows) ? MaxRows : n_rows;
  endfunction

  function automatic bit on_grid(longint unsigned c, longint unsigned r);
    return c < eff_cols() && r < eff_rows();
  endfunction

  function automatic longint unsigned cell_at(longint unsigned c, longint unsigned r);
    return cells[(c + eff_cols() * r) % Depth];
  endfunction

  function automatic longint unsigned fixed_div(longint unsigned s, longint unsigned d);
    longint unsigned q, rm, v;
    q  = s / d;
    rm = s % d;
    if (q > (OutMax >> 8)) return OutMax;
    v = (q << 8) + (rm << 8) / d;
    return (v > OutMax) ? OutMax : v;
  endfunction

  function automatic out_item_t lookup(logic signed [31:0] px, logic signed [31:0] py);
    out_item_t r;
    longint dx, dy;
    longint unsigned sx, sy, i, j, rx, ry, s;
    r  = '{interp_value: '0, status: 1'b1};
    dx = longint'(px) - longint'($signed(org_x));
    dy = longint'(py) - longint'($signed(org_y));
    sx = (stp_x == 0) ? 1 : stp_x;
    sy = (stp_y == 0) ? 1 : stp_y;
    if (dx < 0 || dy < 0) return r;
    i  = dx / sx;  rx = dx % sx;
    j  = dy / sy;  ry = dy % sy;
    if (!on_grid(i, j)) return r;
    if (rx == 0 && ry == 0) begin
      s = fixed_div(cell_at(i, j), 1);
    end else if (rx == 0) begin
      if (!on_grid(i, j + 1)) return r;
      s = fixed_div(cell_at(i, j) * (sy - ry) + cell_at(i, j + 1) * ry, sy);
    end else if (ry == 0) begin
      if (!on_grid(i + 1, j)) return r;
      s = fixed_div(cell_at(i, j) * (sx - rx) + cell_at(i + 1, j) * rx, sx);
    end else begin
      if (!on_grid(i + 1, j + 1)) return r;
      s = cell_at(i, j) * ((sx - rx) * (sy - ry)) + cell_at(i + 1, j) * (rx * (sy - ry))
        + cell_at(i, j + 1) * ((sx - rx) * ry) + cell_at(i + 1, j + 1) * (rx * ry);
      s = fixed_div(s, sx * sy);
    end
    r.interp_value = s[23:0];
    r.status       = 1'b0;
    return r;
  endfunction

  function automatic out_item_t predict(in_item_t it);
    out_item_t r;
    r = '{interp_value: '0, status: 1'b0};
    case (it.cmd)
      CmdWrite: begin
        if (on_grid(it.col, it.row)) cells[(it.col + eff_cols() * it.row) % Depth] = it.cell_value;
        else r.status = 1'b1;
      end
      CmdRead: begin
        if (on_grid(it.col, it.row)) r.interp_value = 24'(cell_at(it.col, it.row) << 8);
        else r.status = 1'b1;
      end
      CmdInterp: r = lookup(it.point_x, it.point_y);
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  task automatic report(string what);
    $display("%0t: mismatch: %s", $realtime, what);
    errors_o++;
  endtask

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      foreach (cells[k]) cells[k] = '0;
      org_x = '0; org_y = '0; stp_x = 16'd1; stp_y = 16'd1;
      n_cols = 7'd64; n_rows = 7'd64;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgOriginX: org_x  = cfg_data_i;
          CfgOriginY: org_y  = cfg_data_i;
          CfgStepX:   stp_x  = cfg_data_i[15:0];
          CfgStepY:   stp_y  = cfg_data_i[15:0];
          CfgCols:    n_cols = cfg_data_i[6:0];
          CfgRows:    n_rows = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (out_item_i.interp_value !== e.interp_value)
            report($sformatf("interp_value got %0h want %0h",
                             out_item_i.interp_value, e.interp_value));
          if (out_item_i.status !== e.status)
            report($sformatf("status got %0b want %0b", out_item_i.status, e.status));
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict(in_item_i));
    end
  end

endmodule

// File: sim/grid_bilinear_interpolator_tb.sv
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_tb: stimulus and verdict
// Runs directed and random phases of cell writes, reads and point lookups
// over several grid settings, with random idling on both sides; the
// checker does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_bilinear_interpolator_tb;
  import gbi_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [CfgIdxBits-1:0]  cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  in_item_t  in_item = '0;
  out_item_t out_item;
  int pending, errors, idle_cycles = 0;
  bit stall_on = 1'b1;

  // grid geometry mirrored here for aiming query points
  logic signed [31:0] ox = 0, oy = 0;
  int sx = 1, sy = 1, nc = 64, nr = 64;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  grid_bilinear_interpolator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  gbi_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_item_i(in_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_item_i(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .pending_o(pending), .errors_o(errors)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    if (!stall_on) out_stall <= 1'b0;
    else if (out_stall) out_stall <= ($urandom_range(99) < 60);
    else out_stall <= ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  // valid stays high after the transfer; drain, or a next send with a gap, drops it
  task automatic send(in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    case (idx)
      CfgOriginX: ox = val;
      CfgOriginY: oy = val;
      CfgStepX:   sx = (val[15:0] == 0) ? 1 : val[15:0];
      CfgStepY:   sy = (val[15:0] == 0) ? 1 : val[15:0];
      CfgCols:    nc = (val[6:0] == 0) ? 1 : (val[6:0] > 64 ? 64 : val[6:0]);
      CfgRows:    nr = (val[6:0] == 0) ? 1 : (val[6:0] > 64 ? 64 : val[6:0]);
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] c, int col, int row, int val,
                                  logic [31:0] px, logic [31:0] py);
    in_item_t it;
    it.cmd = c; it.col = 6'(col); it.row = 6'(row); it.cell_value = 16'(val);
    it.point_x = px; it.point_y = py;
    return it;
  endfunction

  // point near the grid: mostly inside, sometimes exact or on a line, a few past edges
  function automatic in_item_t rand_query();
    longint i, j, rx, ry;
    int k;
    i  = $urandom_range(nc);
    j  = $urandom_range(nr);
    rx = $urandom_range(sx - 1);
    ry = $urandom_range(sy - 1);
    k  = $urandom_range(9);
    if (k < 2) rx = 0;
    if (k == 1 || k == 2) ry = 0;
    if (k == 9) return mk(CmdInterp, 0, 0, 0, $urandom, $urandom);
    return mk(CmdInterp, $urandom, $urandom, $urandom,
              32'(longint'(ox) + i * sx + rx), 32'(longint'(oy) + j * sy + ry));
  endfunction

  function automatic in_item_t rand_item();
    int p;
    p = $urandom_range(99);
    if (p < 30) return mk(CmdWrite, $urandom_range(nc), $urandom_range(nr), $urandom,
                          $urandom, $urandom);
    if (p < 45) return mk(CmdRead, $urandom_range(nc), $urandom_range(nr), 0,
                          $urandom, $urandom);
    if (p < 48) return mk(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
    if (p < 50) return mk(CmdWrite, $urandom, $urandom, $urandom, $urandom, $urandom);
    return rand_query();
  endfunction

  task automatic random_phase(int n);
    repeat (n) send(rand_item());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset geometry, field extremes and error cases
    send(mk(CmdRead, 63, 63, 0, 0, 0));
    send(mk(CmdWrite, 0, 0, 16'hFFFF, 0, 0));
    send(mk(CmdWrite, 1, 0, 16'h0001, 0, 0));
    send(mk(CmdWrite, 0, 1, 16'h8000, 0, 0));
    send(mk(CmdWrite, 1, 1, 16'h1234, 0, 0));
    send(mk(CmdWrite, 63, 63, 16'hABCD, 32'hFFFF_FFFF, 32'h8000_0000));
    send(mk(CmdRead, 0, 0, 16'hFFFF, 0, 0));
    send(mk(CmdRead, 63, 63, 0, 0, 0));
    send(mk(CmdInterp, 0, 0, 0, 0, 0));
    send(mk(CmdInterp, 0, 0, 0, 63, 63));
    send(mk(CmdInterp, 0, 0, 0, 64, 0));
    send(mk(CmdInterp, 0, 0, 0, 32'h8000_0000, 0));
    send(mk(CmdInterp, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send(mk(2'd3, 63, 63, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();

    // fine steps with interior remainders
    write_reg(CfgStepX, 32'd4);
    write_reg(CfgStepY, 32'd3);
    write_reg(CfgCols, 32'd8);
    write_reg(CfgRows, 32'd5);
    write_reg(CfgOriginX, 32'hFFFF_FFF0);
    write_reg(CfgOriginY, 32'd100);
    send(mk(CmdWrite, 8, 0, 1, 0, 0));
    send(mk(CmdInterp, 0, 0, 0, -32'sd14, 32'sd101));
    send(mk(CmdInterp, 0, 0, 0, -32'sd16, 32'sd102));
    send(mk(CmdInterp, 0, 0, 0, -32'sd14, 32'sd100));
    send(mk(CmdInterp, 0, 0, 0, 32'sd12, 32'sd101));
    send(mk(CmdInterp, 0, 0, 0, -32'sd17, 32'sd101));
    drain();
    random_phase(180);
    drain();

    // extreme origins and steps, smallest grid, receiver not stalling
    stall_on = 1'b0;
    write_reg(CfgOriginX, 32'h8000_0000);
    write_reg(CfgOriginY, 32'h7FFF_FFF0);
    write_reg(CfgStepX, 32'hFFFF);
    write_reg(CfgStepY, 32'd0);
    write_reg(CfgCols, 32'd1);
    write_reg(CfgRows, 32'd0);
    random_phase(80);
    drain();
    stall_on = 1'b1;

    // oversize grid values clamp; large steps saturate toward wide sums
    write_reg(CfgOriginX, 32'd0);
    write_reg(CfgOriginY, 32'd0);
    write_reg(CfgCols, 32'h7F);
    write_reg(CfgRows, 32'd65);
    write_reg(CfgStepX, 32'hFFFF);
    write_reg(CfgStepY, 32'hFFFF);
    random_phase(200);
    drain();

    write_reg(CfgCols, 32'd2);
    write_reg(CfgRows, 32'd64);
    write_reg(CfgStepX, 32'd7);
    write_reg(CfgStepY, 32'd1);
    write_reg(CfgOriginX, 32'hC000_0000);
    write_reg(CfgOriginY, 32'h3FFF_FFFF);
    random_phase(230);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
